### hdl/mssr_pkg.sv
// Shared types and constants of the motor soft-start and reversal sequencer.
`default_nettype none

package mssr_pkg;

    // Field widths
    localparam int DUTY_W     = 8;
    localparam int RAMP_W     = 16;
    localparam int REV_W      = 16;
    localparam int MAXRUN_W   = 20;
    localparam int DEB_W      = 10;
    localparam int POL_W      = 4;
    localparam int SPEED_W    = 9;
    localparam int OPCODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int NUM_MOTORS = 4;
    localparam int ARC_MOTORS = 2;

    // Duty clamp: 2^DUTY_BITS-1, never above full PWM scale
    localparam int DUTY_BITS  = 8;
    localparam int DUTY_FULL  = 255;
    localparam int DUTY_LIMIT = (((1 << DUTY_BITS) - 1) < DUTY_FULL) ?
                                ((1 << DUTY_BITS) - 1) : DUTY_FULL;

    // Debounce age saturates here
    localparam logic [DEB_W-1:0] AGE_MAX = '1;

    // Register reset values
    localparam logic [DUTY_W-1:0]   TARGET_DUTY_RST      = DUTY_W'(160);
    localparam logic [RAMP_W-1:0]   RAMP_TIME_RST        = RAMP_W'(1000);
    localparam logic [REV_W-1:0]    REVERSE_INTERVAL_RST = REV_W'(4000);
    localparam logic [MAXRUN_W-1:0] MAX_RUN_TIME_RST     = MAXRUN_W'(30000);
    localparam logic [DEB_W-1:0]    DEBOUNCE_TIME_RST    = DEB_W'(40);
    localparam logic [POL_W-1:0]    POLARITY_INVERT_RST  = POL_W'(8);

    // Command codes
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_DUTY      = 3'd0,
        REG_RAMP_TIME        = 3'd1,
        REG_REVERSE_INTERVAL = 3'd2,
        REG_MAX_RUN_TIME     = 3'd3,
        REG_DEBOUNCE_TIME    = 3'd4,
        REG_POLARITY_INVERT  = 3'd5
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_FIN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_tick;
        logic mul;
        logic div_start;
        logic load_out;
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

### hdl/mssr_tick_if.sv
// Input tick channel: raw button level and command.
`default_nettype none

interface mssr_tick_if import mssr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                button_level;
    logic [OPCODE_W-1:0] opcode;

    modport source (output valid, output button_level, output opcode, input ready);
    modport sink   (input valid, input button_level, input opcode, output ready);
endinterface

`default_nettype wire

### hdl/mssr_result_if.sv
// Result channel: four signed motor speeds, run status and press flag.
`default_nettype none

interface mssr_result_if import mssr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] arc_left_speed;
    logic signed [SPEED_W-1:0] arc_right_speed;
    logic signed [SPEED_W-1:0] roller_left_speed;
    logic signed [SPEED_W-1:0] roller_right_speed;
    logic                      run_active;
    logic                      press_seen;

    modport source (output valid, output arc_left_speed, output arc_right_speed,
                    output roller_left_speed, output roller_right_speed,
                    output run_active, output press_seen, input ready);
    modport sink   (input valid, input arc_left_speed, input arc_right_speed,
                    input roller_left_speed, input roller_right_speed,
                    input run_active, input press_seen, output ready);
endinterface

`default_nettype wire

### hdl/mssr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module mssr_div import mssr_pkg::*; #(
    parameter int NW = 24,
    parameter int DW = 16,
    parameter int QW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [QW-1:0]      quo
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] nq_reg;
    logic [QW-1:0] nq_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [DW:0]   trial;
    logic          fits;

    // One compare/subtract step; numerator bits shift out as quotient bits shift in
    always_comb
    begin
        trial    = {rem_reg, nq_reg[QW-1]};
        fits     = trial >= {1'b0, den};
        rem_next = rem_reg;
        nq_next  = nq_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = DW'(num >> QW);
            nq_next  = num[QW-1:0];
            cnt_next = CW'(QW);
        end
        else if (busy)
        begin
            rem_next = fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
            nq_next  = {nq_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
    end

    assign busy = cnt_reg != '0;
    assign quo  = nq_reg;

`ifndef NO_ASSERTIONS
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !start) |=> (cnt_reg == CW'($past(cnt_reg) - 1'b1)))
        else $error("divider step counter skipped");
`endif

endmodule

`default_nettype wire

### hdl/mssr_ctrl.sv
// Controller state machine: sequences tick intake, multiply, divide and result load.
`default_nettype none

module mssr_ctrl import mssr_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    tick_valid,
    output logic         tick_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (tick_valid) state_next = S_MUL;
            S_MUL:   state_next = S_LOAD;
            S_LOAD:  state_next = S_DIV;
            S_DIV:   if (status.div_done) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Commands and handshake
    always_comb
    begin
        tick_ready     = state_reg == S_IDLE;
        ctrl.take_tick = (state_reg == S_IDLE) && tick_valid;
        ctrl.mul       = state_reg == S_MUL;
        ctrl.div_start = state_reg == S_LOAD;
        ctrl.load_out  = (state_reg == S_FIN) && out_free;
        out_valid_next = ctrl.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |=> !status.div_done)
        else $error("dividers did not pick up the work");
    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result load did not present a transaction");
`endif

endmodule

`default_nettype wire

### hdl/mssr_dpath.sv
// Datapath: registers, debounce, run state, duty ramp and reversal dividers, result.
`default_nettype none

module mssr_dpath import mssr_pkg::*; #(
    parameter int TIME_BITS = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  button_level,
    input  wire logic [OPCODE_W-1:0]   opcode,
    input  wire ctrl_t                 ctrl,
    output status_t                    status,
    output logic signed [SPEED_W-1:0]  arc_left_speed,
    output logic signed [SPEED_W-1:0]  arc_right_speed,
    output logic signed [SPEED_W-1:0]  roller_left_speed,
    output logic signed [SPEED_W-1:0]  roller_right_speed,
    output logic                       run_active,
    output logic                       press_seen
);

    localparam int CMP_W  = (TIME_BITS > MAXRUN_W) ? TIME_BITS : MAXRUN_W;
    localparam int PROD_W = RAMP_W + DUTY_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Configuration registers
    logic [DUTY_W-1:0]   target_duty_reg;
    logic [RAMP_W-1:0]   ramp_time_reg;
    logic [REV_W-1:0]    reverse_interval_reg;
    logic [MAXRUN_W-1:0] max_run_time_reg;
    logic [DEB_W-1:0]    debounce_time_reg;
    logic [POL_W-1:0]    polarity_invert_reg;

    // Debounce and run state
    logic                 last_raw_reg, last_raw_next;
    logic                 stable_reg, stable_next;
    logic [DEB_W-1:0]     age_reg, age_next;
    logic                 run_flag_reg, run_flag_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;

    // Per-tick working values
    logic                 press;
    logic                 run_a, run_b, run_c;
    logic                 clr_a, clr_b;
    logic [TIME_BITS-1:0] elapsed_cur;
    logic                 expired;
    logic                 compute;
    logic                 ramp_on;

    // Snapshots held while the dividers work
    logic [TIME_BITS-1:0] elap_reg;
    logic                 active_reg;
    logic                 ramp_on_reg;
    logic                 press_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [CMP_W-1:0]     elap_ext;

    // Divider results
    logic                 duty_busy, rev_busy;
    logic [DUTY_W-1:0]    duty_quo;
    logic [TIME_BITS-1:0] rev_quo;

    // Result assembly
    logic [DUTY_W-1:0]         duty_sel, duty_cl;
    logic                      arc_rev;
    logic [SPEED_W-1:0]        mag;
    logic [NUM_MOTORS-1:0]     neg;
    logic signed [SPEED_W-1:0] speed_next [NUM_MOTORS];
    logic signed [SPEED_W-1:0] speed_reg  [NUM_MOTORS];
    logic                      run_out_reg, press_out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_duty_reg      <= TARGET_DUTY_RST;
            ramp_time_reg        <= RAMP_TIME_RST;
            reverse_interval_reg <= REVERSE_INTERVAL_RST;
            max_run_time_reg     <= MAX_RUN_TIME_RST;
            debounce_time_reg    <= DEBOUNCE_TIME_RST;
            polarity_invert_reg  <= POLARITY_INVERT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TARGET_DUTY:      target_duty_reg      <= cfg_data[DUTY_W-1:0];
                REG_RAMP_TIME:        ramp_time_reg        <= cfg_data[RAMP_W-1:0];
                REG_REVERSE_INTERVAL: reverse_interval_reg <= cfg_data[REV_W-1:0];
                REG_MAX_RUN_TIME:     max_run_time_reg     <= cfg_data[MAXRUN_W-1:0];
                REG_DEBOUNCE_TIME:    debounce_time_reg    <= cfg_data[DEB_W-1:0];
                REG_POLARITY_INVERT:  polarity_invert_reg  <= cfg_data[POL_W-1:0];
                default: ;
            endcase
        end
    end

    // Debounce: age the raw level, accept it once it held long enough
    always_comb
    begin
        last_raw_next = button_level;
        if (button_level != last_raw_reg)
            age_next = '0;
        else if (age_reg != AGE_MAX)
            age_next = age_reg + 1'b1;
        else
            age_next = age_reg;
        stable_next = stable_reg;
        press       = 1'b0;
        if ((age_next >= debounce_time_reg) && (button_level != stable_reg))
        begin
            stable_next = button_level;
            press       = !button_level;
        end
    end

    // Run state: press toggles, run starts when idle, stop wins, time limit ends
    always_comb
    begin
        run_a       = press ? !run_flag_reg : run_flag_reg;
        clr_a       = press && !run_flag_reg;
        run_b       = (opcode == OP_RUN) ? 1'b1 : run_a;
        clr_b       = clr_a || ((opcode == OP_RUN) && !run_a);
        run_c       = (opcode == OP_STOP) ? 1'b0 : run_b;
        elapsed_cur = clr_b ? '0 : elapsed_reg;
        expired     = CMP_W'(elapsed_cur) >= CMP_W'(max_run_time_reg);
        ramp_on     = CMP_W'(elapsed_cur) < CMP_W'(ramp_time_reg);
        compute     = run_c && !expired;
        run_flag_next = compute;
        if (compute && (elapsed_cur != TIME_MAX))
            elapsed_next = elapsed_cur + 1'b1;
        else
            elapsed_next = elapsed_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b1;
            stable_reg   <= 1'b1;
            age_reg      <= '0;
            run_flag_reg <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (ctrl.take_tick)
        begin
            last_raw_reg <= last_raw_next;
            stable_reg   <= stable_next;
            age_reg      <= age_next;
            run_flag_reg <= run_flag_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // Tick snapshot and ramp product
    assign elap_ext = CMP_W'(elap_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.take_tick)
        begin
            elap_reg    <= elapsed_cur;
            active_reg  <= compute;
            ramp_on_reg <= ramp_on;
            press_reg   <= press;
        end
        if (ctrl.mul)
            prod_reg <= elap_ext[RAMP_W-1:0] * target_duty_reg;
    end

    // Ramp duty: elapsed*target/ramp
    mssr_div #(
        .NW (PROD_W),
        .DW (RAMP_W),
        .QW (DUTY_W)
    ) u_duty_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (prod_reg),
        .den   (ramp_time_reg),
        .busy  (duty_busy),
        .quo   (duty_quo)
    );

    // Reversal phase: elapsed/reverse_interval
    mssr_div #(
        .NW (TIME_BITS),
        .DW (REV_W),
        .QW (TIME_BITS)
    ) u_rev_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (elap_reg),
        .den   (reverse_interval_reg),
        .busy  (rev_busy),
        .quo   (rev_quo)
    );

    assign status.div_done = !duty_busy && !rev_busy;

    // Duty, direction and polarity per motor
    always_comb
    begin
        duty_sel = ramp_on_reg ? duty_quo : target_duty_reg;
        duty_cl  = (duty_sel > DUTY_W'(DUTY_LIMIT)) ? DUTY_W'(DUTY_LIMIT) : duty_sel;
        arc_rev  = (reverse_interval_reg != '0) && rev_quo[0];
        mag      = active_reg ? {1'b0, duty_cl} : '0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            neg[i]        = polarity_invert_reg[i] ^ ((i < ARC_MOTORS) && arc_rev);
            speed_next[i] = neg[i] ? SPEED_W'(-mag) : mag;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
                speed_reg[i] <= speed_next[i];
            run_out_reg   <= active_reg;
            press_out_reg <= press_reg;
        end
    end

    assign arc_left_speed     = speed_reg[0];
    assign arc_right_speed    = speed_reg[1];
    assign roller_left_speed  = speed_reg[2];
    assign roller_right_speed = speed_reg[3];
    assign run_active         = run_out_reg;
    assign press_seen         = press_out_reg;

`ifndef NO_ASSERTIONS
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load_out && !active_reg) |=>
        (speed_reg[0] == '0 && speed_reg[1] == '0 &&
         speed_reg[2] == '0 && speed_reg[3] == '0 && !run_out_reg))
        else $error("stopped tick drove a nonzero speed");
`endif

endmodule

`default_nettype wire

### hdl/motor_soft_start_reversal_sequencer_unit.sv
// A tick taken in S_IDLE passes S_MUL, S_LOAD, S_DIV and S_FIN to result valid;
// the next tick is taken only after that. S_DIV waits on the reversal divider that
// resolves one quotient bit of elapsed/reverse_interval per cycle.
// The result register lets the next tick enter while a result waits to be taken.
// Reset: asynchronous, active low; registers take their defaults, run idle,
// button released. No clearing pass.
`default_nettype none

module motor_soft_start_reversal_sequencer_unit import mssr_pkg::*; #(
    parameter int TIME_BITS = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mssr_tick_if.sink                  tick,
    mssr_result_if.source              result,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_t   ctrl;
    status_t status;

    // Sequencer
    mssr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .status     (status),
        .ctrl       (ctrl)
    );

    // Datapath
    mssr_dpath #(
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .button_level       (tick.button_level),
        .opcode             (tick.opcode),
        .ctrl               (ctrl),
        .status             (status),
        .arc_left_speed     (result.arc_left_speed),
        .arc_right_speed    (result.arc_right_speed),
        .roller_left_speed  (result.roller_left_speed),
        .roller_right_speed (result.roller_right_speed),
        .run_active         (result.run_active),
        .press_seen         (result.press_seen)
    );

endmodule

`default_nettype wire

### bench/motor_soft_start_reversal_sequencer_unit_tb.sv
// Self-checking testbench for the motor soft-start and reversal sequencer.
module motor_soft_start_reversal_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mssr_pkg::*;

    // Unused command code, must be treated like no command
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    localparam int NUM_ROWS        = 32;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 105;
    // Idle wait after the last result is back, as margin
    localparam int DRAIN_WAIT      = 40;
    localparam int CYCLE_LIMIT     = 1000000;

    // One result transaction
    typedef struct packed {
        logic signed [SPEED_W-1:0] arc_left;
        logic signed [SPEED_W-1:0] arc_right;
        logic signed [SPEED_W-1:0] roller_left;
        logic signed [SPEED_W-1:0] roller_right;
        logic                      run_active;
        logic                      press_seen;
    } drive_t;

    // Directed row: either a register write or a tick, optionally with a typed result
    typedef struct {
        logic                  is_cfg;
        cfg_reg_t              reg_id;
        logic [CFG_DATA_W-1:0] value;
        logic                  btn;
        logic [OPCODE_W-1:0]   op;
        logic                  typed;
        drive_t                want;
    } stim_row_t;

    localparam drive_t OUT_IDLE     = '0;
    localparam drive_t OUT_RUN_ZERO = {9'sd0, 9'sd0, 9'sd0, 9'sd0, 1'b1, 1'b0};
    localparam drive_t OUT_PRESS_OFF = {9'sd0, 9'sd0, 9'sd0, 9'sd0, 1'b0, 1'b1};
    localparam drive_t OUT_FULL_160 = {9'sd160, 9'sd160, 9'sd160, -9'sd160, 1'b1, 1'b0};
    localparam drive_t OUT_PRESS_160 = {9'sd160, 9'sd160, 9'sd160, -9'sd160, 1'b1, 1'b1};
    localparam drive_t OUT_ALL_NEG = {-9'sd255, -9'sd255, -9'sd255, -9'sd255, 1'b1, 1'b0};

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mssr_tick_if   tick_ch ();
    mssr_result_if result_ch ();

    motor_soft_start_reversal_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies kept by the predictor
    logic [DUTY_W-1:0]   cfg_target   = TARGET_DUTY_RST;
    logic [RAMP_W-1:0]   cfg_ramp     = RAMP_TIME_RST;
    logic [REV_W-1:0]    cfg_reverse  = REVERSE_INTERVAL_RST;
    logic [MAXRUN_W-1:0] cfg_max_run  = MAX_RUN_TIME_RST;
    logic [DEB_W-1:0]    cfg_debounce = DEBOUNCE_TIME_RST;
    logic [POL_W-1:0]    cfg_polarity = POLARITY_INVERT_RST;

    // Sequencer state kept by the predictor
    logic                run_on     = 1'b0;
    logic [MAXRUN_W-1:0] run_ticks  = '0;
    logic                btn_stable = 1'b1;
    logic                btn_last   = 1'b1;
    logic [DEB_W-1:0]    btn_age    = '0;

    drive_t expected_drive_q [$];
    int     fail_count     = 0;
    int     src_idle_pct   = 0;
    int     sink_stall_pct = 0;
    longint cycle_count    = 0;
    string  field_names [6] = '{"arc_left_speed", "arc_right_speed", "roller_left_speed",
                                "roller_right_speed", "run_active", "press_seen"};

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_NONE,  1'b1, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_STOP,  1'b1, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_SPARE, 1'b1, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b0, OP_NONE,  1'b1, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_RUN,   1'b1, OUT_RUN_ZERO},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_RUN,   1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_STOP,  1'b1, OUT_IDLE},
        // no debounce, no ramp
        '{1'b1, REG_DEBOUNCE_TIME, 20'd0, 1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b1, REG_RAMP_TIME,     20'd0, 1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_RUN,   1'b1, OUT_FULL_160},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b0, OP_NONE,  1'b1, OUT_PRESS_OFF},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_NONE,  1'b1, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b0, OP_NONE,  1'b1, OUT_PRESS_160},
        // full duty, all motors inverted, reversal every tick
        '{1'b1, REG_TARGET_DUTY,      20'd255, 1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b1, REG_POLARITY_INVERT,  20'd15,  1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b1, REG_REVERSE_INTERVAL, 20'd1,   1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b0, OP_NONE,  1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_STOP,  1'b1, OUT_IDLE},
        // reversal disabled
        '{1'b1, REG_REVERSE_INTERVAL, 20'd0, 1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_RUN,   1'b1, OUT_ALL_NEG},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_NONE,  1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_STOP,  1'b1, OUT_IDLE},
        // zero run time stops on the first tick
        '{1'b1, REG_MAX_RUN_TIME,    20'd0, 1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b1, REG_POLARITY_INVERT, 20'd0, 1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_RUN,   1'b1, OUT_IDLE},
        // upper extremes, zero target
        '{1'b1, REG_MAX_RUN_TIME,  20'd1048575, 1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b1, REG_RAMP_TIME,     20'd65535,   1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b1, REG_TARGET_DUTY,   20'd0,       1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b1, REG_DEBOUNCE_TIME, 20'd1023,    1'b1, OP_NONE, 1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_RUN,   1'b1, OUT_RUN_ZERO},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b0, OP_NONE,  1'b0, OUT_IDLE},
        '{1'b0, REG_TARGET_DUTY, '0, 1'b1, OP_STOP,  1'b1, OUT_IDLE}
    };

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Advance the sequencer by one tick and return the drive it produces
    function automatic drive_t advance_sequencer(input logic btn, input logic [OPCODE_W-1:0] op);
        drive_t                    out;
        logic                      press;
        logic [MAXRUN_W-1:0]       elapsed;
        logic [MAXRUN_W-1:0]       quot;
        logic [DUTY_W-1:0]         duty;
        logic signed [SPEED_W-1:0] mag;
        logic [NUM_MOTORS-1:0]     flip;
        logic                      arc_rev;
        out     = '0;
        press   = 1'b0;
        arc_rev = 1'b0;
        // debounce
        if (btn != btn_last) begin
            btn_last = btn;
            btn_age  = '0;
        end else if (btn_age != AGE_MAX) begin
            btn_age = btn_age + 1'b1;
        end
        if (btn_age >= cfg_debounce && btn != btn_stable) begin
            btn_stable = btn;
            press      = !btn;
        end
        // press toggles, then the command
        if (press) begin
            if (run_on) begin
                run_on = 1'b0;
            end else begin
                run_on    = 1'b1;
                run_ticks = '0;
            end
        end
        if (op == OP_RUN && !run_on) begin
            run_on    = 1'b1;
            run_ticks = '0;
        end
        if (op == OP_STOP)
            run_on = 1'b0;
        // ramp, reversal and polarity
        if (run_on) begin
            elapsed = run_ticks;
            if (elapsed >= cfg_max_run) begin
                run_on = 1'b0;
            end else begin
                if (elapsed < cfg_ramp)
                    duty = DUTY_W'((64'(elapsed) * 64'(cfg_target)) / 64'(cfg_ramp));
                else
                    duty = cfg_target;
                if (cfg_reverse != '0) begin
                    quot    = elapsed / MAXRUN_W'(cfg_reverse);
                    arc_rev = quot[0];
                end
                flip = cfg_polarity ^ {2'b00, arc_rev, arc_rev};
                mag  = {1'b0, duty};
                out.arc_left     = flip[0] ? -mag : mag;
                out.arc_right    = flip[1] ? -mag : mag;
                out.roller_left  = flip[2] ? -mag : mag;
                out.roller_right = flip[3] ? -mag : mag;
                if (run_ticks != '1)
                    run_ticks = run_ticks + 1'b1;
            end
        end
        out.run_active = run_on;
        out.press_seen = press;
        return out;
    endfunction

    // Pick a register value: often an extreme, otherwise a small working value
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned lo,
                                                            input int unsigned hi,
                                                            input int unsigned usual_hi);
        int unsigned r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return CFG_DATA_W'(lo);
        if (r == 1)
            return CFG_DATA_W'(hi);
        return CFG_DATA_W'($urandom_range(lo, usual_hi));
    endfunction

    // Write one register; only called while the block is idle
    task automatic write_reg(input cfg_reg_t id, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= id;
        cfg_data  <= value;
        case (id)
            REG_TARGET_DUTY:      cfg_target   = value[DUTY_W-1:0];
            REG_RAMP_TIME:        cfg_ramp     = value[RAMP_W-1:0];
            REG_REVERSE_INTERVAL: cfg_reverse  = value[REV_W-1:0];
            REG_MAX_RUN_TIME:     cfg_max_run  = value[MAXRUN_W-1:0];
            REG_DEBOUNCE_TIME:    cfg_debounce = value[DEB_W-1:0];
            REG_POLARITY_INVERT:  cfg_polarity = value[POL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Send one tick transaction; returns at the accepting edge
    task automatic push_tick(input logic btn, input logic [OPCODE_W-1:0] op,
                             input logic typed, input drive_t want);
        drive_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.button_level <= btn;
        tick_ch.opcode       <= op;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        predicted = advance_sequencer(btn, op);
        expected_drive_q.push_back(typed ? want : predicted);
    endtask

    // Hold off the sender until every result is back and the block is quiet
    task automatic settle_block();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Random traffic: mostly debounced press/release pairs and run sessions
    task automatic run_random_phase(input int count);
        int                  done;
        int                  kind;
        int                  hold;
        int                  r;
        logic                lvl;
        logic [OPCODE_W-1:0] op;
        bit                  paused;
        done   = 0;
        paused = 1'b0;
        while (done < count) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // press then release, each level held past a short debounce window, else for 1 to 12 ticks
                for (int p = 0; p < 2; p++) begin
                    lvl  = (p == 1);
                    hold = (cfg_debounce > 12) ? $urandom_range(1, 12) :
                                                 int'(cfg_debounce) + $urandom_range(1, 3);
                    for (int k = 0; k < hold; k++) begin
                        r = $urandom_range(0, 99);
                        if (r < 80)
                            op = OP_NONE;
                        else if (r < 90)
                            op = OP_RUN;
                        else if (r < 96)
                            op = OP_STOP;
                        else
                            op = OP_SPARE;
                        push_tick(lvl, op, 1'b0, OUT_IDLE);
                        done++;
                    end
                end
            end else if (kind <= 8) begin
                // noise
                hold = $urandom_range(1, 10);
                for (int k = 0; k < hold; k++) begin
                    push_tick(1'($urandom_range(0, 1)), OPCODE_W'($urandom_range(0, 3)),
                              1'b0, OUT_IDLE);
                    done++;
                end
            end else begin
                // long run session to cover ramp, reversals and the run limit
                push_tick(1'b1, OP_RUN, 1'b0, OUT_IDLE);
                done++;
                hold = $urandom_range(20, 80);
                for (int k = 0; k < hold; k++) begin
                    push_tick(1'b1, OP_NONE, 1'b0, OUT_IDLE);
                    done++;
                end
            end
            if (!paused && done >= count / 2) begin
                settle_block();
                paused = 1'b1;
            end
        end
    endtask

    // Receiver backpressure
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // Result checker
    always @(posedge clk) begin : check_result
        drive_t                    want;
        logic signed [SPEED_W-1:0] want_f [6];
        logic signed [SPEED_W-1:0] got_f [6];
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_drive_q.size() == 0) begin
                $display("%0t: result transaction with nothing expected", $time);
                fail_count++;
            end else begin
                want = expected_drive_q.pop_front();
                want_f = '{want.arc_left, want.arc_right, want.roller_left,
                           want.roller_right, SPEED_W'(want.run_active),
                           SPEED_W'(want.press_seen)};
                got_f  = '{result_ch.arc_left_speed, result_ch.arc_right_speed,
                           result_ch.roller_left_speed, result_ch.roller_right_speed,
                           SPEED_W'(result_ch.run_active), SPEED_W'(result_ch.press_seen)};
                for (int i = 0; i < 6; i++) begin
                    if (got_f[i] !== want_f[i]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, field_names[i],
                                 want_f[i], got_f[i]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Main sequence
    initial begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = REG_TARGET_DUTY;
        cfg_data             = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.button_level = 1'b1;
        tick_ch.opcode       = OP_NONE;
        result_ch.ready      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, starting from default registers after reset
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (directed_rows[i].is_cfg) begin
                settle_block();
                write_reg(directed_rows[i].reg_id, directed_rows[i].value);
            end else begin
                push_tick(directed_rows[i].btn, directed_rows[i].op,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // random phases, new settings and idling pattern each time
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle_block();
            write_reg(REG_TARGET_DUTY,      pick_setting(0, 255, 255));
            write_reg(REG_RAMP_TIME,        pick_setting(0, 65535, 60));
            write_reg(REG_REVERSE_INTERVAL, pick_setting(0, 65535, 40));
            write_reg(REG_MAX_RUN_TIME,     pick_setting(0, 1048575, 150));
            write_reg(REG_DEBOUNCE_TIME,    pick_setting(0, 1023, 6));
            write_reg(REG_POLARITY_INVERT,  CFG_DATA_W'($urandom_range(0, 15)));
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            run_random_phase(ITEMS_PER_PHASE);
        end

        settle_block();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
hdl/mssr_pkg.sv
hdl/mssr_tick_if.sv
hdl/mssr_result_if.sv
hdl/mssr_div.sv
hdl/mssr_ctrl.sv
hdl/mssr_dpath.sv
hdl/motor_soft_start_reversal_sequencer_unit.sv
bench/motor_soft_start_reversal_sequencer_unit_tb.sv
